// ===== hw/rtl/fla_pkg.sv =====
// Shared types, constants and codes for the free-list interval allocator.
package fla_pkg;

   localparam int DEF_MAX_INTERVALS = 16;
   localparam int DEF_ADDR_BITS     = 40;
   localparam int FIELD_W           = 40;
   localparam int FREE_W            = 5;
   localparam int STATUS_W          = 2;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_ADDR_W        = 4;

   localparam logic [FIELD_W-1:0] HEAP_LENGTH_RESET = 40'd1048576;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic REG_HEAP_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PREP,
      FSM_EVAL,
      FSM_APPLY
   } fla_state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic init;
      logic prep;
      logic eval;
      logic apply;
      logic kind;
      logic alloc_ok;
      logic down;
      logic down_merge;
      logic up;
      logic up_merge;
      logic insert;
   } fla_ctrl_type;

   // what each cell reports on the first-hit chain
   typedef struct packed {
      logic first;
      logic down;
      logic up;
      logic merge_left;
      logic merge_right;
   } fla_stat_type;

endpackage

// ===== hw/rtl/fla_cell.sv =====
// One free-list entry: holds an interval, evaluates it, shifts with its neighbours.
module fla_cell #(
   parameter int W = fla_pkg::DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fla_pkg::fla_ctrl_type ctrl,
   input  logic                 entry_valid,
   input  logic                 right_valid,
   input  logic                 left_present,
   input  logic [W-1:0]         off,
   input  logic [W-1:0]         len,
   input  logic [W-1:0]         endq,
   input  logic [W-1:0]         init_len,
   input  logic [W-1:0]         left_s,
   input  logic [W-1:0]         left_l,
   input  logic [W-1:0]         left_end,
   input  logic [W-1:0]         right_s,
   input  logic [W-1:0]         right_l,
   input  logic [W-1:0]         right_adjl,
   input  logic                 right_first,
   input  logic                 found_in,
   output logic                 found_out,
   output fla_pkg::fla_stat_type stat,
   output logic [W-1:0]         s_out,
   output logic [W-1:0]         l_out,
   output logic [W-1:0]         end_out,
   output logic [W-1:0]         adjl_out
);

   logic [W-1:0] s_ff, l_ff, end_ff, adjs_ff, adjl_ff;
   logic [W-1:0] s_in, l_in;
   logic         fit_ff, down_ff, up_ff, stop_ff, mergel_ff, merger_ff;
   logic         hit, first;

   always_comb begin
      if (ctrl.kind == fla_pkg::KIND_RELEASE) begin
         hit = entry_valid ? (down_ff | up_ff | stop_ff) : 1'b1;
      end else begin
         hit = entry_valid & fit_ff;
      end
      first     = hit & ~found_in;
      found_out = found_in | hit;
   end

   // an unused slot is only ever an insert position
   assign stat.first       = first;
   assign stat.down        = first & entry_valid & down_ff;
   assign stat.up          = first & entry_valid & ~down_ff & up_ff;
   assign stat.merge_left  = mergel_ff;
   assign stat.merge_right = merger_ff;

   assign s_out    = s_ff;
   assign l_out    = l_ff;
   assign end_out  = end_ff;
   assign adjl_out = adjl_ff;

   // new contents on the apply step
   always_comb begin
      s_in = s_ff;
      l_in = l_ff;
      priority if (ctrl.alloc_ok && first) begin
         s_in = adjs_ff;
         l_in = adjl_ff;
      end else if (ctrl.down_merge && right_first) begin
         l_in = l_ff + right_adjl;
      end else if (ctrl.down_merge && (first || found_in)) begin
         s_in = right_s;
         l_in = right_l;
      end else if (ctrl.down && first) begin
         s_in = adjs_ff;
         l_in = adjl_ff;
      end else if (ctrl.up_merge && first) begin
         l_in = adjl_ff + right_l;
      end else if (ctrl.up_merge && found_in) begin
         s_in = right_s;
         l_in = right_l;
      end else if (ctrl.up && first) begin
         l_in = adjl_ff;
      end else if (ctrl.insert && first) begin
         s_in = off;
         l_in = len;
      end else if (ctrl.insert && found_in) begin
         s_in = left_s;
         l_in = left_l;
      end else begin
         s_in = s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         s_ff <= '0;
         l_ff <= init_len;
      end else if (ctrl.apply) begin
         s_ff <= s_in;
         l_ff <= l_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         end_ff  <= s_ff + l_ff;
         adjs_ff <= (ctrl.kind == fla_pkg::KIND_RELEASE) ? s_ff - len : s_ff + len;
         adjl_ff <= (ctrl.kind == fla_pkg::KIND_RELEASE) ? l_ff + len : l_ff - len;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.eval) begin
         fit_ff    <= (len <= l_ff);
         down_ff   <= (endq == s_ff);
         up_ff     <= (off == end_ff);
         stop_ff   <= (off < s_ff);
         mergel_ff <= left_present && (left_end == adjs_ff);
         merger_ff <= right_valid && (endq == right_s);
      end
   end

endmodule

// ===== hw/rtl/free_list_interval_allocator.sv =====
// Top level of the first-fit free-list interval allocator with coalescing.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    kind, start_offset, length
//  rsp      out        rsp_valid/rsp_ready    status, granted_offset, free_entries
//  csr      in         psel/penable/pready    heap_length at byte address 0
//
// Each transaction goes from acceptance to a registered result through the
// states prepare (sums per cell), evaluate (compares per cell) and apply (first-hit
// chain across the cells and shift of the row); the result register loads
// on the apply edge. A new request is accepted only once the sequencer is back
// in idle. One transaction at a time; the apply step waits while an earlier
// result is still held. Reset, or a heap_length write, reloads the list as one
// interval [0, heap_length).
module free_list_interval_allocator #(
   parameter int MAX_INTERVALS = fla_pkg::DEF_MAX_INTERVALS,
   parameter int ADDR_BITS     = fla_pkg::DEF_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [fla_pkg::FIELD_W-1:0]       req_start_offset,
   input  logic [fla_pkg::FIELD_W-1:0]       req_length,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fla_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fla_pkg::FIELD_W-1:0]       rsp_granted_offset,
   output logic [fla_pkg::FREE_W-1:0]        rsp_free_entries,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fla_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fla_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fla_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int N  = MAX_INTERVALS;
   localparam int W  = ADDR_BITS;
   localparam int CW = $clog2(N + 1);

   fla_pkg::fla_state_type state_ff, state_in;
   fla_pkg::fla_ctrl_type  ctrl;

   logic [fla_pkg::FIELD_W-1:0] heap_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic                        kind_ff;
   logic [W-1:0]                off_ff, len_ff, endq_ff, init_len;

   logic                        rsp_valid_ff;
   logic [fla_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [fla_pkg::FIELD_W-1:0] granted_ff, granted_in;
   logic [fla_pkg::FREE_W-1:0]  free_ff;

   logic                        req_fire, csr_write, out_free, apply_fire;

   logic [W-1:0]                s_w    [N];
   logic [W-1:0]                l_w    [N];
   logic [W-1:0]                end_w  [N];
   logic [W-1:0]                adjl_w [N];
   logic [W-1:0]                left_s_w   [N];
   logic [W-1:0]                left_l_w   [N];
   logic [W-1:0]                left_end_w [N];
   logic [W-1:0]                right_s_w  [N];
   logic [W-1:0]                right_l_w  [N];
   logic [W-1:0]                right_adjl_w [N];
   logic [N-1:0]                valid_w, right_valid_w, right_first_w, left_present_w;
   logic [N:0]                  found_w;
   fla_pkg::fla_stat_type       stat_w [N];

   logic                        any_first, act_down, act_down_merge, act_up, act_up_merge;
   logic                        act_insert, list_full;
   logic [W-1:0]                granted_sel;

   // ---------------- handshakes ----------------
   assign req_fire   = req_valid & req_ready;
   assign csr_write  = psel & penable & pwrite & pready & (paddr[3] == fla_pkg::REG_HEAP_LENGTH);
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign apply_fire = (state_ff == fla_pkg::FSM_APPLY) & out_free;
   assign pready     = 1'b1;
   assign prdata     = (paddr[3] == fla_pkg::REG_HEAP_LENGTH)
                       ? fla_pkg::CSR_DATA_W'(heap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= fla_pkg::HEAP_LENGTH_RESET;
      end else if (csr_write) begin
         heap_ff <= pwdata[fla_pkg::FIELD_W-1:0];
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fla_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fla_pkg::FSM_IDLE:  if (req_fire) state_in = fla_pkg::FSM_PREP;
         fla_pkg::FSM_PREP:  state_in = fla_pkg::FSM_EVAL;
         fla_pkg::FSM_EVAL:  state_in = fla_pkg::FSM_APPLY;
         fla_pkg::FSM_APPLY: if (out_free) state_in = fla_pkg::FSM_IDLE;
         default:            state_in = fla_pkg::FSM_IDLE;
      endcase
   end

   // controls broadcast to the row; the apply actions come from the first hit
   always_comb begin
      req_ready       = (state_ff == fla_pkg::FSM_IDLE);
      ctrl.init       = csr_write;
      ctrl.prep       = (state_ff == fla_pkg::FSM_PREP);
      ctrl.eval       = (state_ff == fla_pkg::FSM_EVAL);
      ctrl.apply      = apply_fire;
      ctrl.kind       = kind_ff;
      ctrl.alloc_ok   = ~kind_ff & any_first;
      ctrl.down       = act_down & ~act_down_merge;
      ctrl.down_merge = act_down_merge;
      ctrl.up         = act_up & ~act_up_merge;
      ctrl.up_merge   = act_up_merge;
      ctrl.insert     = act_insert;
   end

   // request capture; the end of the released range is formed in the prepare state
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         off_ff  <= W'(req_start_offset);
         len_ff  <= W'(req_length);
      end
      if (ctrl.prep) begin
         endq_ff <= off_ff + len_ff;
      end
   end

   assign init_len = reset ? W'(fla_pkg::HEAP_LENGTH_RESET)
                           : W'(pwdata[fla_pkg::FIELD_W-1:0]);

   // ---------------- cell row ----------------
   assign found_w[0] = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign valid_w[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_left_edge
         assign left_present_w[i] = 1'b0;
         assign left_s_w[i]       = '0;
         assign left_l_w[i]       = '0;
         assign left_end_w[i]     = '0;
      end else begin : g_left
         assign left_present_w[i] = 1'b1;
         assign left_s_w[i]       = s_w[i-1];
         assign left_l_w[i]       = l_w[i-1];
         assign left_end_w[i]     = end_w[i-1];
      end

      // past the last cell the list reads as empty zero entries
      if (i == N - 1) begin : g_right_edge
         assign right_valid_w[i] = 1'b0;
         assign right_first_w[i] = 1'b0;
         assign right_s_w[i]     = '0;
         assign right_l_w[i]     = '0;
         assign right_adjl_w[i]  = '0;
      end else begin : g_right
         assign right_valid_w[i] = valid_w[i+1];
         assign right_first_w[i] = stat_w[i+1].first;
         assign right_s_w[i]     = s_w[i+1];
         assign right_l_w[i]     = l_w[i+1];
         assign right_adjl_w[i]  = adjl_w[i+1];
      end

      fla_cell #(
         .W (W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .entry_valid  (valid_w[i]),
         .right_valid  (right_valid_w[i]),
         .left_present (left_present_w[i]),
         .off          (off_ff),
         .len          (len_ff),
         .endq         (endq_ff),
         .init_len     ((i == 0) ? init_len : '0),
         .left_s       (left_s_w[i]),
         .left_l       (left_l_w[i]),
         .left_end     (left_end_w[i]),
         .right_s      (right_s_w[i]),
         .right_l      (right_l_w[i]),
         .right_adjl   (right_adjl_w[i]),
         .right_first  (right_first_w[i]),
         .found_in     (found_w[i]),
         .found_out    (found_w[i+1]),
         .stat         (stat_w[i]),
         .s_out        (s_w[i]),
         .l_out        (l_w[i]),
         .end_out      (end_w[i]),
         .adjl_out     (adjl_w[i])
      );
   end

   // ---------------- decision from the first hit ----------------
   always_comb begin
      any_first      = 1'b0;
      act_down       = 1'b0;
      act_down_merge = 1'b0;
      act_up         = 1'b0;
      act_up_merge   = 1'b0;
      granted_sel    = '0;
      for (int i = 0; i < N; i++) begin
         any_first      = any_first | stat_w[i].first;
         act_down       = act_down | stat_w[i].down;
         act_down_merge = act_down_merge | (stat_w[i].down & stat_w[i].merge_left);
         act_up         = act_up | stat_w[i].up;
         act_up_merge   = act_up_merge | (stat_w[i].up & stat_w[i].merge_right);
         granted_sel    = granted_sel | (stat_w[i].first ? s_w[i] : '0);
      end
      act_down       = act_down & kind_ff;
      act_down_merge = act_down_merge & kind_ff;
      act_up         = act_up & kind_ff;
      act_up_merge   = act_up_merge & kind_ff;
      act_insert     = kind_ff & ~act_down & ~act_up & any_first & (count_ff != CW'(N));
      list_full      = kind_ff & ~act_down & ~act_up & ~act_insert;
   end

   always_comb begin
      count_in   = count_ff;
      status_in  = fla_pkg::ST_OK;
      granted_in = '0;
      if (act_down_merge || act_up_merge) begin
         count_in = count_ff - CW'(1);
      end else if (act_insert) begin
         count_in = count_ff + CW'(1);
      end
      if (kind_ff == fla_pkg::KIND_ALLOC) begin
         if (any_first) begin
            granted_in = fla_pkg::FIELD_W'(granted_sel);
         end else begin
            status_in = fla_pkg::ST_NO_FIT;
         end
      end else if (list_full) begin
         status_in = fla_pkg::ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         count_ff <= CW'(1);
      end else if (apply_fire) begin
         count_ff <= count_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         free_ff    <= fla_pkg::FREE_W'(count_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_offset = granted_ff;
   assign rsp_free_entries   = free_ff;

endmodule

// ===== dv/fla_checker.sv =====
// Scoreboard for the free-list allocator: predicts each response and compares it.
module fla_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_kind,
   input  logic [fla_pkg::FIELD_W-1:0]    req_start_offset,
   input  logic [fla_pkg::FIELD_W-1:0]    req_length,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [fla_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [fla_pkg::FIELD_W-1:0]    rsp_granted_offset,
   input  logic [fla_pkg::FREE_W-1:0]     rsp_free_entries,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fla_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fla_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   output int                             errors,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = fla_pkg::DEF_MAX_INTERVALS;

   typedef struct {
      logic [fla_pkg::STATUS_W-1:0] status;
      logic [fla_pkg::FIELD_W-1:0]  granted;
      logic [fla_pkg::FREE_W-1:0]   free_entries;
   } outcome_type;

   outcome_type                  outcome_q[$];
   logic [fla_pkg::FIELD_W-1:0]  heap_bytes;
   logic [fla_pkg::FIELD_W-1:0]  gap_start[NSLOT];
   logic [fla_pkg::FIELD_W-1:0]  gap_len[NSLOT];
   int                           gap_count;

   assign pending = outcome_q.size();

   function automatic void rebuild_list();
      for (int i = 0; i < NSLOT; i++) begin
         gap_start[i] = '0;
         gap_len[i]   = '0;
      end
      gap_len[0] = heap_bytes;
      gap_count  = 1;
   endfunction

   function automatic void remove_gap(int p);
      for (int i = p; i + 1 < gap_count; i++) begin
         gap_start[i] = gap_start[i+1];
         gap_len[i]   = gap_len[i+1];
      end
      gap_count--;
      gap_start[gap_count] = '0;
      gap_len[gap_count]   = '0;
   endfunction

   function automatic logic [fla_pkg::STATUS_W-1:0] give_back(
      logic [fla_pkg::FIELD_W-1:0] off,
      logic [fla_pkg::FIELD_W-1:0] len);
      logic [fla_pkg::FIELD_W-1:0] stop_at;
      logic [fla_pkg::FIELD_W-1:0] gap_end;
      int                          p;
      int                          grown;
      stop_at = off + len;
      grown   = 0;
      for (p = 0; p < gap_count; p++) begin
         gap_end = gap_start[p] + gap_len[p];
         if (stop_at == gap_start[p]) begin
            gap_start[p] = gap_start[p] - len;
            gap_len[p]   = gap_len[p] + len;
            grown = 1;
            break;
         end else if (off == gap_end) begin
            gap_len[p] = gap_len[p] + len;
            grown = 2;
            break;
         end else if (off < gap_start[p]) begin
            break;
         end
      end
      if (grown == 1) begin
         // grown downward: fold into the left neighbour when they now touch
         if (p > 0 && gap_start[p-1] + gap_len[p-1] == gap_start[p]) begin
            gap_len[p-1] = gap_len[p-1] + gap_len[p];
            remove_gap(p);
         end
         return fla_pkg::ST_OK;
      end
      if (grown == 2) begin
         if (p + 1 < gap_count && gap_start[p] + gap_len[p] == gap_start[p+1]) begin
            gap_start[p+1] = gap_start[p];
            gap_len[p+1]   = gap_len[p+1] + gap_len[p];
            remove_gap(p);
         end
         return fla_pkg::ST_OK;
      end
      if (gap_count >= NSLOT) return fla_pkg::ST_FULL;
      for (int i = gap_count; i > p; i--) begin
         gap_start[i] = gap_start[i-1];
         gap_len[i]   = gap_len[i-1];
      end
      gap_start[p] = off;
      gap_len[p]   = len;
      gap_count++;
      return fla_pkg::ST_OK;
   endfunction

   function automatic outcome_type predict_outcome(logic kind,
                                                   logic [fla_pkg::FIELD_W-1:0] off,
                                                   logic [fla_pkg::FIELD_W-1:0] len);
      outcome_type o;
      o.granted = '0;
      if (kind == fla_pkg::KIND_ALLOC) begin
         o.status = fla_pkg::ST_NO_FIT;
         for (int i = 0; i < gap_count; i++) begin
            if (len <= gap_len[i]) begin
               o.granted    = gap_start[i];
               gap_start[i] = gap_start[i] + len;
               gap_len[i]   = gap_len[i] - len;
               o.status     = fla_pkg::ST_OK;
               break;
            end
         end
      end else begin
         o.status = give_back(off, len);
      end
      o.free_entries = fla_pkg::FREE_W'(gap_count);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         errors     = 0;
         heap_bytes = fla_pkg::HEAP_LENGTH_RESET;
         rebuild_list();
         outcome_q.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr == fla_pkg::CSR_ADDR_W'(8 * fla_pkg::REG_HEAP_LENGTH)) begin
            heap_bytes = pwdata[fla_pkg::FIELD_W-1:0];
            rebuild_list();
         end
         if (req_valid && req_ready)
            outcome_q.push_back(predict_outcome(req_kind, req_start_offset, req_length));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: response with nothing outstanding (status %0d)",
                        $time, rsp_status);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_granted_offset !== want.granted) begin
                  $display("%0t: granted_offset expected %h actual %h",
                           $time, want.granted, rsp_granted_offset);
                  errors++;
               end
               if (rsp_free_entries !== want.free_entries) begin
                  $display("%0t: free_entries expected %0d actual %0d",
                           $time, want.free_entries, rsp_free_entries);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ===== dv/free_list_interval_allocator_tb.sv =====
// Top of the allocator testbench: stimulus, CSR writes, watchdog and verdict.
module free_list_interval_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  STALL_LIMIT = 5000;   // cycles with no transaction at all
   localparam int  PER_PHASE   = 90;
   localparam logic [fla_pkg::FIELD_W-1:0] ALL_ONES = '1;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_kind = fla_pkg::KIND_ALLOC;
   logic [fla_pkg::FIELD_W-1:0]    req_start_offset = '0;
   logic [fla_pkg::FIELD_W-1:0]    req_length = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [fla_pkg::STATUS_W-1:0]   rsp_status;
   logic [fla_pkg::FIELD_W-1:0]    rsp_granted_offset;
   logic [fla_pkg::FREE_W-1:0]     rsp_free_entries;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [fla_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [fla_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [fla_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   int                             errors;
   int                             pending;
   int                             tx_idle_pct = 0;   // sender gap probability, percent
   int                             rx_idle_pct = 0;   // receiver stall probability, percent
   int                             quiet_cycles = 0;
   logic [fla_pkg::FIELD_W-1:0]    heap_now = fla_pkg::HEAP_LENGTH_RESET;

   free_list_interval_allocator u_dut (.*);

   fla_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   // watchdog: any handshake on any port counts as progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [fla_pkg::FIELD_W-1:0] rand_field();
      return fla_pkg::FIELD_W'({$urandom, $urandom});
   endfunction

   // one request transaction; valid held until accepted, optional gap first
   task automatic issue(logic kind, logic [fla_pkg::FIELD_W-1:0] off,
                        logic [fla_pkg::FIELD_W-1:0] len);
      logic ready_seen;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_start_offset <= off;
      req_length       <= len;
      do begin
         // ready only moves on a rising edge, so the falling edge sees it settled
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_heap(logic [fla_pkg::FIELD_W-1:0] bytes);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= fla_pkg::CSR_ADDR_W'(8 * fla_pkg::REG_HEAP_LENGTH);
      pwdata  <= fla_pkg::CSR_DATA_W'(bytes);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      heap_now = bytes;
   endtask

   // mostly grant/return traffic inside the heap, with some wild noise
   task automatic random_traffic(int count);
      logic [63:0]                 span;
      logic [fla_pkg::FIELD_W-1:0] off;
      logic [fla_pkg::FIELD_W-1:0] len;
      int                          pick;
      span = 64'(heap_now) + 1;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = fla_pkg::FIELD_W'({$urandom, $urandom} % (span / 4 + 1));
            issue(fla_pkg::KIND_ALLOC, rand_field(), len);
         end else if (pick < 90) begin
            off = fla_pkg::FIELD_W'({$urandom, $urandom} % span)
                  & ~fla_pkg::FIELD_W'(8'hff);
            len = fla_pkg::FIELD_W'({$urandom, $urandom} % (span / 16 + 1));
            issue(fla_pkg::KIND_RELEASE, off, len);
         end else begin
            issue(pick[0] ? fla_pkg::KIND_RELEASE : fla_pkg::KIND_ALLOC,
                  rand_field(), rand_field());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset heap of 1 MiB
      tx_idle_pct = 21;
      rx_idle_pct = 74;
      issue(fla_pkg::KIND_ALLOC, ALL_ONES, '0);                  // zero-length grant
      issue(fla_pkg::KIND_ALLOC, '0, ALL_ONES);                  // nothing fits
      issue(fla_pkg::KIND_ALLOC, '0, fla_pkg::HEAP_LENGTH_RESET); // exact fit, empty entry kept
      issue(fla_pkg::KIND_ALLOC, '0, '0);
      issue(fla_pkg::KIND_ALLOC, '0, 40'd1);                     // no fit on empty entry
      issue(fla_pkg::KIND_RELEASE, '0, 40'h1000);                // insert ahead of entry
      issue(fla_pkg::KIND_RELEASE, 40'h1000, 40'h1000);          // grow upward
      issue(fla_pkg::KIND_RELEASE, 40'h2000,
            fla_pkg::HEAP_LENGTH_RESET - 40'h2000);              // upward + right merge
      issue(fla_pkg::KIND_ALLOC, '0, 40'h8000);
      issue(fla_pkg::KIND_ALLOC, '0, 40'h8000);
      issue(fla_pkg::KIND_RELEASE, 40'h4000, 40'h4000);          // insert ahead of entry
      issue(fla_pkg::KIND_RELEASE, 40'h4000, 40'h4000);          // double release
      issue(fla_pkg::KIND_RELEASE, 40'h20000, '0);               // zero-length insert
      issue(fla_pkg::KIND_RELEASE, ALL_ONES, ALL_ONES);          // wrap of the end
      issue(fla_pkg::KIND_RELEASE, '0, '0);
      // fill the list until a release is dropped
      for (int i = 0; i < 18; i++)
         issue(fla_pkg::KIND_RELEASE, 40'h200000 + 40'(i) * 40'h1000, 40'h10);

      random_traffic(PER_PHASE / 2);
      drain();                                                   // sender holds off
      random_traffic(PER_PHASE / 2);
      drain();

      tx_idle_pct = 74;
      rx_idle_pct = 21;
      write_heap('0);
      issue(fla_pkg::KIND_ALLOC, '0, '0);
      issue(fla_pkg::KIND_ALLOC, '0, 40'd1);
      random_traffic(PER_PHASE / 3);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_heap(ALL_ONES);
      issue(fla_pkg::KIND_ALLOC, '0, ALL_ONES);
      issue(fla_pkg::KIND_RELEASE, '0, ALL_ONES);
      random_traffic(PER_PHASE);
      drain();

      write_heap(40'h1000);
      random_traffic(PER_PHASE);
      drain();

      write_heap(rand_field() >> $urandom_range(30));
      random_traffic(PER_PHASE);
      drain();

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
